FILE: design/scfa_pkg.sv
`timescale 1ns / 1ps

package scfa_pkg;

    localparam int ADDR_W     = 48;
    localparam int MARK_W     = 8;
    localparam int LEN_W      = 14;
    localparam int CLASS_W    = 3;
    localparam int STATUS_W   = 2;
    localparam int WORD_BITS  = 32;
    localparam int WORD_LOG   = 5;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W  = 1;

    localparam logic [MARK_W-1:0] MARK_RESET = 8'd245;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_MARK  = 1'b1;

    typedef enum logic
    {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_FREE  = 2'd2
    } status_t;

    typedef struct packed
    {
        logic capture;
        logic base;
        logic offset;
        logic check;
        logic scan;
        logic clear_bit;
        logic finish;
        logic fail_exhaust;
        logic fail_bad;
        logic load_out;
        logic sweep;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic sweep_done;
        logic bad_class;
        logic is_free;
        logic no_frames;
        logic bad_free;
        logic hit;
        logic scan_end;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/scfa_dp.sv
`timescale 1ns / 1ps

module scfa_dp
    import scfa_pkg::*;
#(
    parameter int REGION_BYTES    = 65536,
    parameter int CLASS_COUNT     = 8,
    parameter int MIN_FRAME_BYTES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]    m_tuser,
    input  ctrl_cmd_t              cmd,
    output dp_stat_t               stat
);

    localparam int MIN_LOG    = $clog2(MIN_FRAME_BYTES);
    localparam int MAX_FRAMES = REGION_BYTES / MIN_FRAME_BYTES;
    localparam int MAX_ROWS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int IDX_W      = ROW_W + WORD_LOG;
    localparam int CNT_W      = IDX_W + 1;
    localparam int VIS_W      = ROW_W + 2;
    localparam int CLS_W      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int MEM_AW     = CLS_W + ROW_W;
    localparam int MEM_DEPTH  = 1 << MEM_AW;
    localparam int LOWM_W     = MIN_LOG + 8;
    localparam int SH_W       = $clog2(LOWM_W);
    localparam int SPAN_W     = $clog2(REGION_BYTES) + 1;

    function automatic logic [SH_W-1:0] shift_of(logic [CLASS_W-1:0] c);
        return SH_W'(MIN_LOG) + SH_W'(c);
    endfunction

    function automatic logic [CNT_W-1:0] frames_of(logic [CLASS_W-1:0] c);
        logic [SPAN_W-1:0] r;
        r = SPAN_W'(REGION_BYTES) >> shift_of(c);
        return CNT_W'(r);
    endfunction

    function automatic logic [SPAN_W-1:0] span_of(logic [CLASS_W-1:0] c);
        return SPAN_W'(frames_of(c)) << shift_of(c);
    endfunction

    function automatic logic [ROW_W-1:0] last_row_of(logic [CLASS_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = frames_of(c) - CNT_W'(1);
        return n[IDX_W-1:WORD_LOG];
    endfunction

    function automatic logic [WORD_BITS-1:0] tail_mask_of(logic [CLASS_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = frames_of(c);
        if (n[WORD_LOG-1:0] == '0)
        begin
            return '1;
        end
        return (WORD_BITS'(1) << n[WORD_LOG-1:0]) - WORD_BITS'(1);
    endfunction

    function automatic logic [LEN_W-1:0] len_of(logic [CLASS_W-1:0] c);
        return LEN_W'(MIN_FRAME_BYTES) << c;
    endfunction

    function automatic logic [ADDR_W-1:0] class_off_of(logic [CLASS_W-1:0] c);
        return ADDR_W'(c) * ADDR_W'(REGION_BYTES);
    endfunction

    logic [ADDR_W-1:0]    region_base_reg;
    logic [MARK_W-1:0]    mark_reg;
    func_t                func_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic [ADDR_W-1:0]    off_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [ROW_W-1:0]     row_reg;
    logic                 first_reg;
    logic [VIS_W-1:0]     visits_reg;
    logic [IDX_W-1:0]     next_index_reg [1 << CLS_W];
    logic [MEM_AW-1:0]    sweep_reg;
    logic [WORD_BITS-1:0] mem [MEM_DEPTH];
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [ADDR_W-1:0]    res_addr_reg;
    status_t              res_status_reg;
    logic [LEN_W-1:0]     res_len_reg;
    logic [MARK_W-1:0]    res_mark_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    status_t              out_status_reg;
    logic [LEN_W-1:0]     out_len_reg;
    logic [MARK_W-1:0]    out_mark_reg;
    logic                 out_valid_reg;

    logic [CLS_W-1:0]     cls_idx;
    logic [CNT_W-1:0]     n_frames;
    logic [SH_W-1:0]      shift;
    logic [ROW_W-1:0]     last_row;
    logic [ROW_W-1:0]     row_next;
    logic [IDX_W-1:0]     cur_index;
    logic [IDX_W-1:0]     start_index;
    logic [IDX_W-1:0]     free_index;
    logic [IDX_W-1:0]     next_index;
    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] low_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [WORD_LOG-1:0]  bitpos;
    logic [LOWM_W-1:0]    low_bits;
    logic                 hit;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_waddr;
    logic [MEM_AW-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    assign cls_idx   = cls_reg[CLS_W-1:0];
    assign n_frames  = frames_of(cls_reg);
    assign shift     = shift_of(cls_reg);
    assign last_row  = last_row_of(cls_reg);
    assign row_next  = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
    assign cur_index = next_index_reg[cls_idx];
    assign start_index = ({1'b0, cur_index} >= n_frames) ? '0 : cur_index;
    assign free_index  = IDX_W'(off_reg >> shift);
    assign next_index  = ({1'b0, idx_reg} + CNT_W'(1) == n_frames) ? '0 : idx_reg + IDX_W'(1);
    assign low_bits    = (LOWM_W'(1) << shift) - LOWM_W'(1);

    assign valid_mask = (row_reg == last_row) ? tail_mask_of(cls_reg) : '1;
    assign low_mask   = first_reg ? ('1 << idx_reg[WORD_LOG-1:0]) : '1;
    assign free_vec   = ~rd_word_reg & valid_mask & low_mask;
    assign hit        = |free_vec;

    always_comb
    begin
        bitpos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                bitpos = WORD_LOG'(b);
            end
        end
    end

    always_comb
    begin
        stat.sweep_done = (sweep_reg == '1);
        stat.bad_class  = ({1'b0, cls_reg} >= (CLASS_W + 1)'(CLASS_COUNT));
        stat.is_free    = (func_reg == FUNC_FREE);
        stat.no_frames  = (n_frames == '0);
        stat.bad_free   = (off_reg >= ADDR_W'(span_of(cls_reg)))
                          || ((off_reg[LOWM_W-1:0] & low_bits) != '0);
        stat.hit        = hit;
        stat.scan_end   = (visits_reg == VIS_W'(1));
        stat.out_free   = !out_valid_reg || m_tready;
    end

    assign mem_raddr = {cls_idx, cmd.scan ? row_next : row_reg};

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {cls_idx, row_reg};
        mem_wdata = rd_word_reg;
        priority if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = '0;
        end
        else if (cmd.scan && hit)
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_word_reg | (WORD_BITS'(1) << bitpos);
        end
        else if (cmd.clear_bit)
        begin
            mem_we    = 1'b1;
            mem_wdata = rd_word_reg & ~(WORD_BITS'(1) << idx_reg[WORD_LOG-1:0]);
        end
        else
        begin
            mem_we    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_word_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            mark_reg        <= MARK_RESET;
            sweep_reg       <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < (1 << CLS_W); i++)
            begin
                next_index_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REGION_BASE: region_base_reg <= cfg_data;
                    CFG_AFTER_MARK:  mark_reg        <= cfg_data[MARK_W-1:0];
                endcase
            end
            if (cmd.sweep)
            begin
                sweep_reg <= sweep_reg + MEM_AW'(1);
            end
            if (cmd.finish)
            begin
                next_index_reg[cls_idx] <= next_index;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func_t'(s_tuser);
            cls_reg  <= s_tdata[CLASS_W-1:0];
            addr_reg <= s_tdata[CLASS_W +: ADDR_W];
        end
        if (cmd.base)
        begin
            base_reg   <= region_base_reg + class_off_of(cls_reg);
            idx_reg    <= start_index;
            row_reg    <= start_index[IDX_W-1:WORD_LOG];
            first_reg  <= 1'b1;
            visits_reg <= VIS_W'(last_row) + VIS_W'(2);
        end
        if (cmd.offset)
        begin
            off_reg <= addr_reg - base_reg;
        end
        if (cmd.check)
        begin
            idx_reg <= free_index;
            row_reg <= free_index[IDX_W-1:WORD_LOG];
        end
        if (cmd.scan)
        begin
            if (hit)
            begin
                idx_reg <= {row_reg, bitpos};
            end
            else
            begin
                row_reg    <= row_next;
                first_reg  <= 1'b0;
                visits_reg <= visits_reg - VIS_W'(1);
            end
        end
        priority if (cmd.fail_exhaust || cmd.fail_bad)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= cmd.fail_bad ? ST_BAD_FREE : ST_EXHAUSTED;
            res_len_reg    <= '0;
            res_mark_reg   <= '0;
        end
        else if (cmd.clear_bit)
        begin
            res_addr_reg   <= addr_reg;
            res_status_reg <= ST_OK;
            res_len_reg    <= len_of(cls_reg);
            res_mark_reg   <= mark_reg;
        end
        else if (cmd.finish)
        begin
            res_addr_reg   <= base_reg + (ADDR_W'(idx_reg) << shift);
            res_status_reg <= ST_OK;
            res_len_reg    <= len_of(cls_reg);
            res_mark_reg   <= '0;
        end
        else
        begin
            res_addr_reg   <= res_addr_reg;
            res_status_reg <= res_status_reg;
            res_len_reg    <= res_len_reg;
            res_mark_reg   <= res_mark_reg;
        end
        if (cmd.load_out)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_len_reg    <= res_len_reg;
            out_mark_reg   <= res_mark_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - ADDR_W - LEN_W - MARK_W){1'b0}},
                       out_mark_reg, out_len_reg, out_addr_reg};
    assign m_tuser  = out_status_reg;

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken word");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK)
        |-> (out_addr_reg == '0 && out_len_reg == '0 && out_mark_reg == '0))
        else $error("error result carries nonzero payload");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> ({1'b0, idx_reg} < n_frames))
        else $error("allocated frame index beyond class");

endmodule

FILE: design/scfa_ctrl.sv
`timescale 1ns / 1ps

module scfa_ctrl
    import scfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [3:0]
    {
        S_CLEAR,
        S_IDLE,
        S_BASE,
        S_OFFSET,
        S_CHECK,
        S_READ,
        S_SCAN,
        S_CLRBIT,
        S_FOUND,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = S_BASE;
                end
            end
            S_BASE:
            begin
                cmd.base = 1'b1;
                priority if (stat.bad_class)
                begin
                    cmd.fail_bad     = stat.is_free;
                    cmd.fail_exhaust = !stat.is_free;
                    state_next       = S_DONE;
                end
                else if (stat.is_free)
                begin
                    state_next = S_OFFSET;
                end
                else if (stat.no_frames)
                begin
                    cmd.fail_exhaust = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_OFFSET:
            begin
                cmd.offset = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (stat.bad_free)
                begin
                    cmd.fail_bad = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = stat.is_free ? S_CLRBIT : S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                priority if (stat.hit)
                begin
                    state_next = S_FOUND;
                end
                else if (stat.scan_end)
                begin
                    cmd.fail_exhaust = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_CLRBIT:
            begin
                cmd.clear_bit = 1'b1;
                state_next    = S_DONE;
            end
            S_FOUND:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.load_out = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word taken while a request is in progress");

endmodule

FILE: design/size_class_frame_allocator.sv
// Size-class frame allocator.
// Requests arrive on the s_ stream: s_tuser is the request kind (allocate or free),
// s_tdata carries the size class and, for a free, the frame address.
// Every request returns exactly one word on the m_ stream: frame address, poison
// length and poison mark in m_tdata, the status in m_tuser.
// The user writes registers via cfg_we / cfg_index / cfg_data only while idle; the block does not enforce it.
// Busy bits live in one memory of 32-bit words, one row per 32 frames of a class.
// A free runs through the base, offset, check, read and clear-bit states to done (from
// check straight to done when the address is rejected); an allocate runs base, read,
// a circular scan of the busy words (1 to rows + 1 words, one word per cycle; at most 33
// at default sizes) and found. An exhausted class answers once the scan ends, an out-of-range class from base.
// One request is in work at a time; the next word is taken in the idle state entered
// as the result is registered, so a new request waits until the last one is through.
// Reset clears the search indices and starts a clearing pass over the busy memory,
// one word per cycle (256 words at default sizes); s_tready stays low until it ends.
// When the receiver stalls, the finished word holds in the output register; the block
// still takes and works on one more request and then waits to hand it over.
`timescale 1ns / 1ps

module size_class_frame_allocator
    import scfa_pkg::*;
#(
    parameter int REGION_BYTES    = 65536,
    parameter int CLASS_COUNT     = 8,
    parameter int MIN_FRAME_BYTES = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // size_class, free_address
    input  logic                   s_tuser,   // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // frame_address, poison_length, poison_mark
    output logic [STATUS_W-1:0]    m_tuser    // status
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    scfa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scfa_dp
    #(
        .REGION_BYTES    (REGION_BYTES),
        .CLASS_COUNT     (CLASS_COUNT),
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

FILE: verif/tb_size_class_frame_allocator.sv
`timescale 1ns / 1ps

module tb_size_class_frame_allocator;
    import scfa_pkg::*;

    localparam int REGION_BYTES    = 65536;
    localparam int MIN_FRAME_BYTES = 64;
    localparam int CLASS_FRAMES0   = REGION_BYTES / MIN_FRAME_BYTES;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int SETTLE_CYCLES   = 60;

    typedef struct
    {
        func_t             func;
        logic [2:0]        cls;
        logic [ADDR_W-1:0] addr;
    } request_t;

    typedef struct
    {
        logic [ADDR_W-1:0] addr;
        status_t           status;
        logic [LEN_W-1:0]  len;
        logic [MARK_W-1:0] mark;
    } reply_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_REGION_BASE;
    logic [ADDR_W-1:0]      cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    size_class_frame_allocator u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // allocator state mirror
    bit                frame_busy [8][CLASS_FRAMES0];
    int                search_from [8];
    logic [ADDR_W-1:0] base_reg = '0;
    logic [MARK_W-1:0] mark_reg = MARK_RESET;

    request_t req_queue[$];
    reply_t   reply_due[$];
    request_t tx_item;
    int       issued_count = 0;
    int       taken_count = 0;
    int       reply_count = 0;
    int       error_count = 0;
    int       tx_wait = 0;
    int       rx_wait = 0;
    int       rx_gap = 0;
    int       idle_cycles = 0;
    bit       tx_burst = 1'b0;
    bit       rx_burst = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] region_start(input logic [2:0] c);
        return base_reg + ADDR_W'(c) * ADDR_W'(REGION_BYTES);
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_W-1:0];
    endfunction

    function automatic reply_t serve_request(input request_t r);
        reply_t            res;
        int                n;
        int                idx;
        bit                found;
        logic [ADDR_W-1:0] fb;
        logic [ADDR_W-1:0] off;
        n = CLASS_FRAMES0 >> r.cls;
        fb = ADDR_W'(MIN_FRAME_BYTES) << r.cls;
        res.addr = '0;
        res.len = '0;
        res.mark = '0;
        found = 1'b0;
        if (r.func == FUNC_ALLOC)
        begin
            res.status = ST_EXHAUSTED;
            idx = search_from[r.cls];
            if (idx >= n)
                idx = 0;
            for (int k = 0; k < n && !found; k++)
            begin
                if (!frame_busy[r.cls][idx])
                begin
                    found = 1'b1;
                    frame_busy[r.cls][idx] = 1'b1;
                    search_from[r.cls] = (idx + 1 == n) ? 0 : idx + 1;
                    res.addr = region_start(r.cls) + ADDR_W'(idx) * fb;
                    res.status = ST_OK;
                    res.len = fb[LEN_W-1:0];
                end
                else
                    idx = (idx + 1 == n) ? 0 : idx + 1;
            end
        end
        else
        begin
            off = r.addr - region_start(r.cls);
            if (off >= ADDR_W'(n) * fb || (off % fb) != 0)
                res.status = ST_BAD_FREE;
            else
            begin
                frame_busy[r.cls][int'(off / fb)] = 1'b0;
                res.addr = r.addr;
                res.status = ST_OK;
                res.len = fb[LEN_W-1:0];
                res.mark = mark_reg;
            end
        end
        return res;
    endfunction

    task automatic push_request(input func_t f, input int c, input logic [ADDR_W-1:0] a);
        request_t r;
        r.func = f;
        r.cls = 3'(c);
        r.addr = a;
        req_queue.push_back(r);
        issued_count++;
    endtask

    function automatic logic [ADDR_W-1:0] frame_at(input int c, input int idx);
        return region_start(3'(c)) + ADDR_W'(idx) * (ADDR_W'(MIN_FRAME_BYTES) << c);
    endfunction

    task automatic queue_traffic(input int count, input int alloc_pct);
        int                c;
        int                n;
        int                fb;
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < count; i++)
        begin
            c = ($urandom_range(0, 9) < 7) ? $urandom_range(4, 7) : $urandom_range(0, 3);
            n = CLASS_FRAMES0 >> c;
            fb = MIN_FRAME_BYTES << c;
            if ($urandom_range(0, 99) < alloc_pct)
                push_request(FUNC_ALLOC, c, rand_addr());
            else if ($urandom_range(0, 9) < 8)
                push_request(FUNC_FREE, c, frame_at(c, $urandom_range(0, n - 1)));
            else
            begin
                case ($urandom_range(0, 3))
                    0: a = rand_addr();
                    1: a = frame_at(c, $urandom_range(0, n - 1)) + ADDR_W'($urandom_range(1, fb - 1));
                    2: a = region_start(3'(c)) - ADDR_W'(fb * $urandom_range(1, 3));
                    default: a = frame_at(c, n + $urandom_range(0, 2));
                endcase
                push_request(FUNC_FREE, c, a);
            end
        end
    endtask

    task automatic drain();
        while (taken_count != issued_count || reply_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_REGION_BASE)
            base_reg = value;
        else
            mark_reg = value[MARK_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            tx_wait <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                reply_due.push_back(serve_request(tx_item));
                taken_count++;
            end
            if (tx_wait != 0)
            begin
                s_tvalid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end
            else if (req_queue.size() != 0)
            begin
                tx_item = req_queue.pop_front();
                s_tdata <= {5'd0, tx_item.addr, tx_item.cls};
                s_tuser <= tx_item.func;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    tx_burst = !tx_burst;
                tx_wait <= tx_burst ? 0 : $urandom_range(0, 13);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    task automatic check_reply();
        reply_t want;
        if (reply_due.size() == 0)
        begin
            $display("%0t unexpected word: expected none, actual %h / %0d", $time, m_tdata, m_tuser);
            error_count++;
        end
        else
        begin
            want = reply_due.pop_front();
            if (m_tdata[47:0] !== want.addr)
            begin
                $display("%0t frame_address: expected %h, actual %h", $time, want.addr, m_tdata[47:0]);
                error_count++;
            end
            if (m_tuser !== want.status)
            begin
                $display("%0t status: expected %0d, actual %0d", $time, want.status, m_tuser);
                error_count++;
            end
            if (m_tdata[61:48] !== want.len)
            begin
                $display("%0t poison_length: expected %0d, actual %0d", $time, want.len, m_tdata[61:48]);
                error_count++;
            end
            if (m_tdata[69:62] !== want.mark)
            begin
                $display("%0t poison_mark: expected %0d, actual %0d", $time, want.mark, m_tdata[69:62]);
                error_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_reply();
            reply_count++;
            // hold off long enough to back the block up into its input
            if (reply_count % 500 == 250)
                rx_gap = LONG_HOLD;
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    rx_burst = !rx_burst;
                rx_gap = rx_burst ? 0 : $urandom_range(0, 13);
            end
            m_tready <= (rx_gap == 0);
            rx_wait <= (rx_gap == 0) ? 0 : rx_gap - 1;
        end
        else if (rx_wait != 0)
        begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[size_class_frame_allocator] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // one frame from every class, then run class 7 dry
        for (int c = 0; c < 8; c++)
            push_request(FUNC_ALLOC, c, '0);
        for (int i = 0; i < 8; i++)
            push_request(FUNC_ALLOC, 7, {ADDR_W{1'b1}});
        push_request(FUNC_FREE, 7, frame_at(7, 3));
        push_request(FUNC_FREE, 7, frame_at(7, 3));
        push_request(FUNC_ALLOC, 7, '0);
        push_request(FUNC_FREE, 0, frame_at(0, 0) + ADDR_W'(32));
        push_request(FUNC_FREE, 1, region_start(3'd1) - ADDR_W'(MIN_FRAME_BYTES));
        push_request(FUNC_FREE, 2, region_start(3'd2) + ADDR_W'(REGION_BYTES));
        push_request(FUNC_FREE, 0, {ADDR_W{1'b1}});
        queue_traffic(300, 60);
        drain();

        set_reg(CFG_REGION_BASE, {ADDR_W{1'b1}} - ADDR_W'(2 * REGION_BYTES) + ADDR_W'(1));
        set_reg(CFG_AFTER_MARK, '0);
        queue_traffic(300, 55);
        drain();

        set_reg(CFG_REGION_BASE, {ADDR_W{1'b1}});
        set_reg(CFG_AFTER_MARK, ADDR_W'(8'hFF));
        queue_traffic(300, 50);
        drain();

        set_reg(CFG_REGION_BASE, rand_addr());
        set_reg(CFG_AFTER_MARK, ADDR_W'($urandom_range(0, 255)));
        queue_traffic(350, 65);
        drain();

        set_reg(CFG_REGION_BASE, '0);
        set_reg(CFG_AFTER_MARK, ADDR_W'(MARK_RESET));
        queue_traffic(350, 40);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("[size_class_frame_allocator] OK");
        else
            $display("[size_class_frame_allocator] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
design/scfa_pkg.sv
design/scfa_dp.sv
design/scfa_ctrl.sv
design/size_class_frame_allocator.sv
verif/tb_size_class_frame_allocator.sv
